### hdl/mlfs_pkg.sv
`timescale 1ns / 1ps
package mlfs_pkg;

   localparam int BANKS          = 4;
   localparam int COLORS         = 4;
   localparam int SLOTS_PER_BANK = 4;
   localparam int COLOR_SEL_W    = 2;

   localparam int CH_W    = 4;
   localparam int LEVEL_W = 12;
   localparam int CNT_W   = 13;
   localparam int ITER_W  = $clog2(CNT_W + 1);

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   localparam logic [CNT_W-1:0]   TOTAL_STEPS = CNT_W'(4096);
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(4095);
   localparam logic [CH_W-1:0]    LAST_CH     =
      CH_W'((BANKS - 1) * SLOTS_PER_BANK + COLORS - 1);

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_LOAD = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD_DIV,
      ST_CHAN,
      ST_DIV,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic            latch;
      logic            tick;
      logic            load_wr;
      logic            div_start;
      logic            div_tick;
      logic            width_wr;
      logic            emit;
      logic            last;
      logic [CH_W-1:0] ch;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_load;
      logic slot_ok;
      logic mag_zero;
      logic fin;
      logic width_zero;
      logic div_done;
      logic out_free;
   } sts_type;

   function automatic logic slot_valid(logic [CH_W-1:0] ch);
      logic [CH_W-1:0] bank;
      logic [CH_W-1:0] color;
      bank  = ch >> COLOR_SEL_W;
      color = CH_W'(ch[COLOR_SEL_W-1:0]);
      return (int'(bank) < BANKS) && (int'(color) < COLORS);
   endfunction

endpackage

### hdl/mlfs_divider.sv
`timescale 1ns / 1ps
module mlfs_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mlfs_pkg::CNT_W-1:0] dividend,
   input  logic [mlfs_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [mlfs_pkg::CNT_W-1:0] quotient,
   output logic [mlfs_pkg::CNT_W-1:0] remainder
);
   import mlfs_pkg::*;

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   logic [CNT_W:0] shifted;
   logic           ge;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[CNT_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = ITER_W'(CNT_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? CNT_W'(shifted - {1'b0, dsr_ff}) : shifted[CNT_W-1:0];
         quo_in = {quo_ff[CNT_W-2:0], ge};
         cnt_in = cnt_ff - ITER_W'(1);
         if (cnt_ff == ITER_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hdl/mlfs_datapath.sv
`timescale 1ns / 1ps
module mlfs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  mlfs_pkg::cmd_type               cmd,
   output mlfs_pkg::sts_type               sts,
   input  logic [mlfs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mlfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [mlfs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import mlfs_pkg::*;

   // latched transaction
   logic               is_load_ff;
   logic [CH_W-1:0]    item_ch_ff;
   logic [LEVEL_W-1:0] start_ff;
   logic [LEVEL_W-1:0] target_ff;
   logic               drive_ff;

   logic [LEVEL_W-1:0] level_ff [BANKS*SLOTS_PER_BANK];
   logic [CNT_W-1:0]   width_ff [BANKS*SLOTS_PER_BANK];
   logic               down_ff  [BANKS*SLOTS_PER_BANK];
   logic [CNT_W-1:0]   counter_ff, counter_in;

   logic                  out_valid_ff, out_valid_in;
   logic [CH_W-1:0]       out_ch_ff;
   logic [LEVEL_W-1:0]    out_level_ff;
   logic                  out_write_ff;
   logic                  out_fin_ff;
   logic                  out_last_ff;

   logic               ramp_down;
   logic [LEVEL_W-1:0] mag;
   logic [LEVEL_W-1:0] start_clamped;
   logic               fin;
   logic [LEVEL_W-1:0] cur_level;
   logic [CNT_W-1:0]   cur_width;
   logic               stepped;
   logic [LEVEL_W-1:0] next_level;
   logic               out_free;

   logic               div_done;
   logic [CNT_W-1:0]   div_dividend;
   logic [CNT_W-1:0]   div_divisor;
   logic [CNT_W-1:0]   div_quo;
   logic [CNT_W-1:0]   div_rem;

   assign ramp_down     = target_ff < start_ff;
   assign mag           = ramp_down ? start_ff - target_ff : target_ff - start_ff;
   assign start_clamped = (start_ff > LEVEL_MAX) ? LEVEL_MAX : start_ff;
   assign fin           = counter_ff >= TOTAL_STEPS;
   assign cur_level     = level_ff[cmd.ch];
   assign cur_width     = width_ff[cmd.ch];
   assign out_free      = !out_valid_ff || rsp_tready;

   // remainder is only meaningful when the divider ran for this channel
   assign stepped = !fin && (cur_width != '0) && (div_rem == '0);

   always_comb begin
      next_level = cur_level;
      if (down_ff[cmd.ch]) begin
         if (cur_level != '0) begin
            next_level = cur_level - LEVEL_W'(1);
         end
      end else begin
         if (cur_level < LEVEL_MAX) begin
            next_level = cur_level + LEVEL_W'(1);
         end
      end
   end

   assign div_dividend = cmd.div_tick ? counter_ff : TOTAL_STEPS;
   assign div_divisor  = cmd.div_tick ? cur_width : CNT_W'(mag);

   mlfs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      counter_in = counter_ff;
      if (cmd.load_wr) begin
         counter_in = '0;
      end else if (cmd.tick && (counter_ff < TOTAL_STEPS)) begin
         counter_in = counter_ff + CNT_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < BANKS*SLOTS_PER_BANK; i++) begin
            level_ff[i] <= '0;
            width_ff[i] <= '0;
            down_ff[i]  <= 1'b0;
         end
      end else begin
         counter_ff   <= counter_in;
         out_valid_ff <= out_valid_in;
         if (cmd.load_wr) begin
            level_ff[item_ch_ff] <= start_clamped;
            down_ff[item_ch_ff]  <= ramp_down;
         end
         if (cmd.width_wr) begin
            width_ff[item_ch_ff] <= (mag == '0) ? '0 : div_quo;
         end
         if (cmd.emit && stepped) begin
            level_ff[cmd.ch] <= next_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         is_load_ff <= req_tuser;
         item_ch_ff <= req_tdata[CH_W-1:0];
         start_ff   <= req_tdata[CH_W +: LEVEL_W];
         target_ff  <= req_tdata[CH_W+LEVEL_W +: LEVEL_W];
         drive_ff   <= req_tdata[CH_W+2*LEVEL_W];
      end
      if (cmd.emit) begin
         out_ch_ff    <= cmd.ch;
         out_level_ff <= stepped ? next_level : cur_level;
         out_write_ff <= stepped && drive_ff;
         out_fin_ff   <= fin;
         out_last_ff  <= cmd.last;
      end
   end

   assign sts.is_load    = (is_load_ff == ACT_LOAD);
   assign sts.slot_ok    = slot_valid(item_ch_ff);
   assign sts.mag_zero   = (mag == '0);
   assign sts.fin        = fin;
   assign sts.width_zero = (cur_width == '0);
   assign sts.div_done   = div_done;
   assign sts.out_free   = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_level_ff, out_ch_ff};
   assign rsp_tuser  = {out_fin_ff, out_write_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

### hdl/mlfs_ctrl.sv
`timescale 1ns / 1ps
module mlfs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mlfs_pkg::sts_type sts,
   output mlfs_pkg::cmd_type cmd
);
   import mlfs_pkg::*;

   state_type       state_ff, state_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic            at_last;

   assign at_last = (ch_ff == LAST_CH);

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_load) begin
               if (!sts.slot_ok || sts.mag_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LOAD_DIV;
               end
            end else begin
               ch_in    = '0;
               state_in = ST_CHAN;
            end
         end
         ST_LOAD_DIV: begin
            if (sts.div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHAN: begin
            if (!slot_valid(ch_ff)) begin
               ch_in = ch_ff + CH_W'(1);
            end else if (sts.fin || sts.width_zero) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = ST_CHAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.ch     = ch_ff;
      cmd.last   = at_last;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         ST_DECODE: begin
            if (sts.is_load) begin
               if (sts.slot_ok) begin
                  cmd.load_wr   = 1'b1;
                  cmd.width_wr  = sts.mag_zero;
                  cmd.div_start = !sts.mag_zero;
               end
            end else begin
               cmd.tick = 1'b1;
            end
         end
         ST_LOAD_DIV: begin
            cmd.width_wr = sts.div_done;
         end
         ST_CHAN: begin
            if (slot_valid(ch_ff) && !sts.fin && !sts.width_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_tick  = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_tick = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

### hdl/multichannel_linear_fade_stepper.sv
`timescale 1ns / 1ps
// Linear fade engine for sixteen LED color channels (four banks of four colors). A load
// transaction (req_tuser = 1) sets one channel's level and computes its step width,
// 4096 / |target - start|, on a shared one-bit-per-cycle divider (zero, without a
// division, when start equals target); a load to a channel outside the configured
// banks/colors is dropped. A tick transaction (req_tuser = 0) advances the shared step
// counter and walks the channels in ascending order, one result per channel with tlast
// on the final one. Each unfinished channel whose width is nonzero runs the same divider
// to test counter modulo width; idle or finished channels skip it, and rsp_tready stalls
// hold the walk. The next transaction is taken as soon as the last result is in the
// output register.
module multichannel_linear_fade_stepper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] channel, [15:4] start_level, [27:16] target_level, [28] drive_output
   input  logic [mlfs_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] out_channel, [15:4] level
   output logic [mlfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] write_pwm, [1] finished
   output logic [mlfs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import mlfs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mlfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mlfs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hdl/mlfs_checker.sv
`timescale 1ns / 1ps
module mlfs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [mlfs_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mlfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mlfs_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                            rsp_tlast
);
   import mlfs_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a finishing tick never flags a PWM write
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("write flagged on finished result");

   // the run of results closes on the highest channel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3:0] == LAST_CH)
      else $error("tlast on wrong channel");

   // a load produces no result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACT_LOAD) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after load");

   // a tick keeps the input closed while channels are walked
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACT_TICK) |=> !req_tready)
      else $error("input reopened during tick");

endmodule

bind multichannel_linear_fade_stepper mlfs_checker u_mlfs_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import mlfs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 5_000_000;
   localparam int NUM_CH       = 1 << CH_W;
   localparam int RANDOM_ITEMS = 200;
   localparam int FINISH_TICKS = 4100;
   localparam int DRAIN_CYCLES = 400;

   typedef struct packed {
      action_type         act;
      logic [CH_W-1:0]    ch;
      logic [LEVEL_W-1:0] start_lv;
      logic [LEVEL_W-1:0] target_lv;
      logic               drive;
      // known answer for one channel of a tick, overrides the prediction
      logic               typed;
      logic [CH_W-1:0]    t_ch;
      logic [LEVEL_W-1:0] t_level;
      logic               t_write;
      logic               t_fin;
   } fade_cmd_type;

   typedef struct packed {
      logic [CH_W-1:0]    ch;
      logic [LEVEL_W-1:0] level;
      logic               write_pwm;
      logic               finished;
      logic               last;
   } fade_rsp_type;

   localparam fade_cmd_type DIRECTED [21] = '{
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b1, 1'b1, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd0,  12'd4095,  12'd0,     1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b1, 1'b1, 4'd0,  12'd4094, 1'b1, 1'b0},
      '{ACT_LOAD, 4'd15, 12'd0,     12'd4095,  1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b0, 1'b1, 4'd15, 12'd1,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd1,  12'd100,   12'd100,   1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b1, 1'b1, 4'd1,  12'd100,  1'b0, 1'b0},
      '{ACT_LOAD, 4'd2,  12'd0,     12'd1,     1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd3,  12'd4095,  12'd4094,  1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd4,  12'd0,     12'd2,     1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd5,  12'd4000,  12'd4095,  1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd6,  12'd2,     12'd0,     1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b1, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b1, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd7,  12'hAAA,   12'h555,   1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd8,  12'h555,   12'hAAA,   1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b1, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_LOAD, 4'd9,  12'd4095,  12'd4095,  1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b0, 1'b1, 4'd9,  12'd4095, 1'b0, 1'b0},
      '{ACT_LOAD, 4'd10, 12'd0,     12'd0,     1'b0, 1'b0, 4'd0,  12'd0,    1'b0, 1'b0},
      '{ACT_TICK, 4'd0,  12'd0,     12'd0,     1'b1, 1'b1, 4'd10, 12'd0,    1'b0, 1'b0}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // predicted fade state
   logic [LEVEL_W-1:0] ch_level [NUM_CH];
   logic [CNT_W-1:0]   ch_width [NUM_CH];
   logic               ch_down  [NUM_CH];
   logic [CNT_W-1:0]   tick_count;

   fade_rsp_type levels_due[$];
   int           errors      = 0;
   bit           idle_on     = 1'b0;
   int           stall_left  = 0;
   int unsigned  cycle_count = 0;

   multichannel_linear_fade_stepper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit channel_present(logic [CH_W-1:0] ch);
      return (int'(ch) / SLOTS_PER_BANK < BANKS) && (int'(ch) % SLOTS_PER_BANK < COLORS);
   endfunction

   // Apply one accepted transaction to the predicted state, queue the levels it reports.
   task automatic advance_fade(input fade_cmd_type c);
      int           mag;
      int           first;
      bit           fin;
      bit           stepped;
      fade_rsp_type r;
      if (c.act == ACT_LOAD) begin
         if (!channel_present(c.ch))
            return;
         ch_level[c.ch] = (c.start_lv > LEVEL_MAX) ? LEVEL_MAX : c.start_lv;
         if (c.target_lv >= c.start_lv) begin
            mag = int'(c.target_lv) - int'(c.start_lv);
            ch_down[c.ch] = 1'b0;
         end else begin
            mag = int'(c.start_lv) - int'(c.target_lv);
            ch_down[c.ch] = 1'b1;
         end
         ch_width[c.ch] = (mag != 0) ? CNT_W'(int'(TOTAL_STEPS) / mag) : '0;
         if (mag == 0)
            ch_down[c.ch] = 1'b0;
         tick_count = '0;
         return;
      end
      if (tick_count < TOTAL_STEPS)
         tick_count = tick_count + 1'b1;
      fin   = (tick_count >= TOTAL_STEPS);
      first = levels_due.size();
      for (int i = 0; i < NUM_CH; i++) begin
         if (channel_present(CH_W'(i))) begin
            stepped = 1'b0;
            if (!fin && ch_width[i] != 0 && (tick_count % ch_width[i]) == 0) begin
               stepped = 1'b1;
               if (ch_down[i]) begin
                  if (ch_level[i] > 0)
                     ch_level[i] = ch_level[i] - 1'b1;
               end else if (ch_level[i] < LEVEL_MAX) begin
                  ch_level[i] = ch_level[i] + 1'b1;
               end
            end
            r.ch        = CH_W'(i);
            r.level     = ch_level[i];
            r.write_pwm = stepped && c.drive;
            r.finished  = fin;
            r.last      = 1'b0;
            levels_due.push_back(r);
         end
      end
      if (levels_due.size() > first)
         levels_due[levels_due.size()-1].last = 1'b1;
      if (c.typed) begin
         for (int i = first; i < levels_due.size(); i++) begin
            if (levels_due[i].ch == c.t_ch) begin
               levels_due[i].level     = c.t_level;
               levels_due[i].write_pwm = c.t_write;
               levels_due[i].finished  = c.t_fin;
            end
         end
      end
   endtask

   // Called at a rising edge; returns at the edge that accepts the transaction.
   task automatic send_fade_cmd(input fade_cmd_type c);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.act;
      req_tdata  <= REQ_DATA_W'({c.drive, c.target_lv, c.start_lv, c.ch});
      do @(posedge clock); while (!req_tready);
      advance_fade(c);
   endtask

   // Hold the sender until every predicted level has come out.
   task automatic wait_levels_due();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (levels_due.size() != 0);
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      fade_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (levels_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual ch %0d level %0d",
                     $time, rsp_tdata[3:0], rsp_tdata[15:4]);
         end else begin
            want = levels_due.pop_front();
            check_field("out_channel", want.ch, rsp_tdata[3:0]);
            check_field("level", want.level, rsp_tdata[15:4]);
            check_field("write_pwm", want.write_pwm, rsp_tuser[0]);
            check_field("finished", want.finished, rsp_tuser[1]);
            check_field("last", want.last, rsp_tlast);
         end
      end
      if (idle_on && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      fade_cmd_type cmd;
      int           sent;
      int           n;
      int           d;
      for (int i = 0; i < NUM_CH; i++) begin
         ch_level[i] = '0;
         ch_width[i] = '0;
         ch_down[i]  = 1'b0;
      end
      tick_count = '0;
      sent       = 0;
      repeat (8) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      foreach (DIRECTED[k])
         send_fade_cmd(DIRECTED[k]);
      wait_levels_due();

      while (sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) begin
            // noise: any field combination
            cmd           = '0;
            cmd.act       = action_type'($urandom_range(0, 1));
            cmd.ch        = CH_W'($urandom);
            cmd.start_lv  = LEVEL_W'($urandom);
            cmd.target_lv = LEVEL_W'($urandom);
            cmd.drive     = 1'($urandom_range(0, 1));
            send_fade_cmd(cmd);
            sent++;
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               cmd          = '0;
               cmd.act      = ACT_LOAD;
               cmd.ch       = CH_W'($urandom);
               cmd.start_lv = LEVEL_W'($urandom);
               case ($urandom_range(0, 3))
                  0: cmd.target_lv = LEVEL_W'($urandom);
                  1: cmd.target_lv = cmd.start_lv;
                  // wide swing gives a short step width, so the channel moves often
                  2: cmd.target_lv = cmd.start_lv[LEVEL_W-1] ?
                                     LEVEL_W'($urandom_range(0, 1023)) :
                                     LEVEL_W'($urandom_range(3072, 4095));
                  default: begin
                     d = $urandom_range(1, 8);
                     cmd.target_lv = (int'(cmd.start_lv) + d > int'(LEVEL_MAX)) ?
                                     cmd.start_lv - LEVEL_W'(d) : cmd.start_lv + LEVEL_W'(d);
                  end
               endcase
               send_fade_cmd(cmd);
               sent++;
            end
            n = $urandom_range(1, 16);
            repeat (n) begin
               cmd           = '0;
               cmd.act       = ACT_TICK;
               cmd.ch        = CH_W'($urandom);
               cmd.start_lv  = LEVEL_W'($urandom);
               cmd.target_lv = LEVEL_W'($urandom);
               cmd.drive     = 1'($urandom_range(0, 1));
               send_fade_cmd(cmd);
               sent++;
            end
         end
      end
      wait_levels_due();

      // Full fade to the finish: three channels move, two of them to saturation, the rest hold.
      idle_on = 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
         cmd     = '0;
         cmd.act = ACT_LOAD;
         cmd.ch  = CH_W'(i);
         case (i)
            5: begin
               cmd.start_lv  = 12'd1095;
               cmd.target_lv = 12'd4095;
            end
            6: begin
               cmd.start_lv  = 12'd3000;
               cmd.target_lv = 12'd0;
            end
            9: begin
               cmd.start_lv  = 12'd200;
               cmd.target_lv = 12'd2248;
            end
            default: begin
               cmd.start_lv  = LEVEL_W'($urandom);
               cmd.target_lv = cmd.start_lv;
            end
         endcase
         send_fade_cmd(cmd);
      end
      repeat (FINISH_TICKS) begin
         cmd       = '0;
         cmd.act   = ACT_TICK;
         cmd.drive = 1'($urandom_range(0, 1));
         send_fade_cmd(cmd);
      end
      // a load after the finish restarts the counter
      cmd           = '0;
      cmd.act       = ACT_LOAD;
      cmd.ch        = '0;
      cmd.start_lv  = 12'd10;
      cmd.target_lv = 12'd4000;
      send_fade_cmd(cmd);
      cmd       = '0;
      cmd.act   = ACT_TICK;
      cmd.drive = 1'b1;
      send_fade_cmd(cmd);

      req_tvalid <= 1'b0;
      while (levels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
